/* hdl/frl_pkg.sv */
// Shared types and constants for the frame ring allocator.
`default_nettype none

package frl_pkg;

  // Width of a byte mark (head, tail, capacity, frame marks).
  localparam int unsigned MARK_W = 25;
  // Width of a returned offset.
  localparam int unsigned ADDR_BITS = 24;
  // Allocations are rounded up to a multiple of 256 bytes.
  localparam int unsigned ROUND_MASK = 255;
  // Default depth of the frame mark queue.
  localparam int unsigned FRAME_DEPTH_DEF = 8;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FINISH = 2'd1,
    OP_POP    = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_QFULL  = 2'd2,
    ST_QEMPTY = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [MARK_W-1:0]   size;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] offset;
    status_t              status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input item
    logic commit;  // execute the captured item and load the result register
  } dp_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic queue_empty;
    logic queue_full;
  } dp_status_t;

endpackage

`default_nettype wire

/* hdl/frame_ring_allocator.sv */
// Frame ring allocator top level: controller, datapath and checks.
// A result is written to the output register when its item commits in the execute state,
// which waits while out_stall holds an older result. One item is held until it commits;
// a pending result waits in the output register, so the next item is taken meanwhile.
// Reset (rst_n low, synchronous) clears head, tail, capacity and the frame queue count;
// the frame mark RAM is not cleared, since the count guards every read of it.
`default_nettype none

module frame_ring_allocator #(
  parameter int unsigned FRAME_DEPTH = frl_pkg::FRAME_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire frl_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output frl_pkg::out_item_t              out_data,
  input  wire logic                       cfg_wr_en,
  input  wire logic [frl_pkg::MARK_W-1:0] cfg_wr_data
);
  import frl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  frl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  frl_dp #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .out_data    (out_data),
    .sts         (sts)
  );

  // Only one item is held: a transfer in closes the input for the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is in flight");

  // The frame queue cannot be empty and full at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.queue_empty && sts.queue_full))
    else $error("frame queue both empty and full");

  // Any result other than a grant carries a zero offset.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.offset == '0)
    else $error("nonzero offset on a refused result");

endmodule

`default_nettype wire

/* hdl/frl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module frl_ram #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/frl_ctrl.sv */
// Controller for the frame ring allocator: input handshake and result valid.
`default_nettype none

module frl_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output frl_pkg::dp_cmd_t    cmd
);
  import frl_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The result register is free when empty or being drained this cycle.
  assign slot_free = !out_valid_r || !out_stall;

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.commit = (state_r == S_EXEC) && slot_free;

  // Next state and result valid.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/frl_dp.sv */
// Datapath for the frame ring allocator: marks, capacity, frame queue, result.
`default_nettype none

module frl_dp #(
  parameter int unsigned FRAME_DEPTH = frl_pkg::FRAME_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [frl_pkg::MARK_W-1:0] cfg_wr_data,
  input  wire frl_pkg::in_item_t          in_data,
  input  wire frl_pkg::dp_cmd_t           cmd,
  output frl_pkg::out_item_t              out_data,
  output frl_pkg::dp_status_t             sts
);
  import frl_pkg::*;

  localparam int unsigned PTR_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FRAME_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FRAME_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_DEPTH);

  // Captured item.
  opcode_t           op_r;
  logic [MARK_W-1:0] size_r;

  // Allocator state.
  logic [MARK_W-1:0] cap_r, head_r, tail_r;
  logic [MARK_W-1:0] head_nxt, tail_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, wr_ptr_r, rd_ptr_nxt, wr_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // Result register.
  out_item_t out_r, out_nxt;

  // Frame mark queue storage.
  logic              mark_we;
  logic [MARK_W-1:0] mark_rdata;

  // Allocation arithmetic.
  logic [MARK_W:0]   span_from_tail;
  logic              wrap;
  logic [MARK_W-1:0] start;
  logic [MARK_W:0]   span_end;
  logic              too_big;
  logic              blocked;
  logic [MARK_W:0]   rounded;

  logic q_empty, q_full;

  assign q_empty = (cnt_r == '0);
  assign q_full  = (cnt_r == CNT_FULL);
  assign sts.queue_empty = q_empty;
  assign sts.queue_full  = q_full;
  assign out_data = out_r;

  // Start offset: at the tail, or back at zero if the span overruns capacity.
  assign span_from_tail = {1'b0, tail_r} + {1'b0, size_r};
  assign wrap     = span_from_tail > {1'b0, cap_r};
  assign start    = wrap ? '0 : tail_r;
  assign span_end = {1'b0, start} + {1'b0, size_r};
  assign too_big  = size_r > cap_r;
  assign blocked  = (start < head_r) && (span_end >= {1'b0, head_r});
  assign rounded  = ({1'b0, size_r} + (MARK_W + 1)'(ROUND_MASK))
                    & ~((MARK_W + 1)'(ROUND_MASK));

  frl_ram #(
    .WIDTH (MARK_W),
    .DEPTH (FRAME_DEPTH)
  ) u_marks (
    .clk   (clk),
    .we    (mark_we),
    .waddr (wr_ptr_r),
    .wdata (tail_r),
    .raddr (rd_ptr_r),
    .rdata (mark_rdata)
  );

  // Execute the captured item. The read pointer changes only on a commit and the
  // controller passes through idle between commits, so the registered mark read is current.
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    out_nxt    = out_r;
    mark_we    = 1'b0;
    if (cmd.commit) begin
      out_nxt.offset = '0;
      out_nxt.status = ST_OK;
      unique case (op_r)
        OP_ALLOC: begin
          if (too_big || blocked) begin
            out_nxt.status = ST_FULL;
          end else begin
            tail_nxt       = start + rounded[MARK_W-1:0];
            out_nxt.offset = start[ADDR_BITS-1:0];
          end
        end
        OP_FINISH: begin
          if (q_full) begin
            out_nxt.status = ST_QFULL;
          end else begin
            mark_we    = 1'b1;
            wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
            cnt_nxt    = cnt_r + 1'b1;
          end
        end
        OP_POP: begin
          if (q_empty) begin
            out_nxt.status = ST_QEMPTY;
          end else begin
            head_nxt   = mark_rdata;
            rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
            cnt_nxt    = cnt_r - 1'b1;
          end
        end
        OP_NONE: begin
          out_nxt.status = ST_OK;
        end
        default: begin
          out_nxt.status = ST_OK;
        end
      endcase
    end
  end

  // Control state: marks, pointers, count and capacity.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Captured item and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_data.opcode;
      size_r <= in_data.size;
    end
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire
